### src/mteu_pkg.sv
// mteu_pkg: shared constants and types for the multi-turn encoder unwrap block
// used by the channel interfaces and the top level; no dependencies

package mteu_pkg;

  // payload widths
  localparam int CH_W       = 3;
  localparam int RAW_W      = 16;
  localparam int POS_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // absolute encoder geometry
  localparam int ANGLE_BITS   = 14;
  localparam int ABS_CHANNELS = 4;
  localparam int ABS_IDX_W    = (ABS_CHANNELS > 1) ? $clog2(ABS_CHANNELS) : 1;
  localparam int OFFSET_REGS  = 4;
  localparam int OFF_IDX_W    = 2;
  localparam int INC_CHANNELS = 2;

  localparam logic [ANGLE_BITS-1:0] ANGLE_MASK = {ANGLE_BITS{1'b1}};
  // one turn step is 2^ANGLE_BITS - 1, not 2^ANGLE_BITS
  localparam logic [POS_W-1:0]      TURN_STEP  = POS_W'(ANGLE_MASK);

  // incremental count modulus and its reciprocal for a raw-width numerator
  localparam int INC_MODULUS = 272;
  localparam int INC_RECIP   = (1 << RAW_W) / INC_MODULUS;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW    = 3'd7;

  // configuration reset values
  localparam logic [OFFSET_REGS-1:0] INVERT_RST = 4'd6;
  localparam logic [ANGLE_BITS-1:0]  JUMP_RST   = 14'd15000;
  localparam logic signed [15:0]     HIGH_RST   = 16'sd6000;
  localparam logic signed [15:0]     LOW_RST    = -16'sd5000;

  typedef logic [CH_W-1:0]         chan_t;
  typedef logic [RAW_W-1:0]        raw_t;
  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic [ANGLE_BITS-1:0]   angle_t;

endpackage

### src/mteu_in_if.sv
// mteu_in_if: reading channel (channel number and raw value) with valid/ready
// depends on mteu_pkg

interface mteu_in_if;
  logic              valid;
  logic              ready;
  mteu_pkg::chan_t   channel;
  mteu_pkg::raw_t    raw_value;

  modport source (output valid, output channel, output raw_value, input ready);
  modport sink   (input valid, input channel, input raw_value, output ready);
endinterface

### src/mteu_out_if.sv
// mteu_out_if: position channel (channel echo and position) with valid/ready
// depends on mteu_pkg

interface mteu_out_if;
  logic              valid;
  logic              ready;
  mteu_pkg::chan_t   channel_echo;
  mteu_pkg::pos_t    position;

  modport source (output valid, output channel_echo, output position, input ready);
  modport sink   (input valid, input channel_echo, input position, output ready);
endinterface

### src/multi_turn_encoder_unwrap.sv
// multi_turn_encoder_unwrap: per-channel multi-turn unwrap of absolute encoder angles
// depends on mteu_pkg, mteu_in_if, mteu_out_if
//
// One reading enters per cycle unless back-pressure stalls it; its position leaves
// through the input register, then the result register. With out_bus.ready held
// high the block sustains one transaction per clock. The rate is set by the
// read-modify-write of the per-channel angle and turn correction registers in
// the second stage: a reading for a channel sees the state left by the reading
// just before it, even on the same channel in back-to-back cycles. Channels 0..3
// are absolute encoders (14-bit angle, optional mirror, wrap tracking, zero
// offset and limit fold), channels 4 and 5 return the raw value modulo 272, and
// channels 6 and 7 return zero and touch no state. Configuration writes are
// taken on any cycle with cfg_we high and must only happen while idle.

module multi_turn_encoder_unwrap (
  input  logic                                clk,
  input  logic                                rst_n,
  mteu_in_if.sink                             in_bus,
  mteu_out_if.source                          out_bus,
  input  logic                                cfg_we,
  input  logic [mteu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mteu_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int POS_W = mteu_pkg::POS_W;
  localparam int RAW_W = mteu_pkg::RAW_W;
  localparam int AB    = mteu_pkg::ANGLE_BITS;

  // configuration registers
  logic [POS_W-1:0]                  zero_off_r [mteu_pkg::OFFSET_REGS];
  logic [mteu_pkg::OFFSET_REGS-1:0]  invert_r;
  logic [AB-1:0]                     jump_r;
  logic [15:0]                       high_r;
  logic [15:0]                       low_r;

  // per-channel unwrap state
  logic [AB-1:0]    last_angle_r [mteu_pkg::ABS_CHANNELS];
  logic [POS_W-1:0] turn_corr_r  [mteu_pkg::ABS_CHANNELS];

  // input stage
  logic                 s1_valid_r;
  mteu_pkg::chan_t      s1_ch_r;
  mteu_pkg::raw_t       s1_raw_r;
  logic [RAW_W-1:0]     s1_quot_r;
  logic [AB-1:0]        s1_angle_r;
  logic [POS_W-1:0]     s1_zero_r;
  logic [POS_W-1:0]     s1_a_mz_r;

  // result stage
  logic                 out_valid_r;
  mteu_pkg::chan_t      out_ch_r;
  logic [POS_W-1:0]     out_pos_r;

  // ---------------------------------------------------------------- handshake
  logic out_load;
  logic s1_adv;

  assign out_load     = !out_valid_r || out_bus.ready;
  assign s1_adv       = s1_valid_r && out_load;
  assign in_bus.ready = !s1_valid_r || out_load;

  logic in_take;
  assign in_take = in_bus.valid && in_bus.ready;

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mteu_pkg::OFFSET_REGS; i++) begin
        zero_off_r[i] <= '0;
      end
      invert_r <= mteu_pkg::INVERT_RST;
      jump_r   <= mteu_pkg::JUMP_RST;
      high_r   <= mteu_pkg::HIGH_RST;
      low_r    <= mteu_pkg::LOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        mteu_pkg::CFG_ZERO0, mteu_pkg::CFG_ZERO1,
        mteu_pkg::CFG_ZERO2, mteu_pkg::CFG_ZERO3: begin
          zero_off_r[cfg_index[mteu_pkg::OFF_IDX_W-1:0]] <= cfg_wdata;
        end
        mteu_pkg::CFG_INVERT: invert_r <= cfg_wdata[mteu_pkg::OFFSET_REGS-1:0];
        mteu_pkg::CFG_JUMP:   jump_r   <= cfg_wdata[AB-1:0];
        mteu_pkg::CFG_HIGH:   high_r   <= cfg_wdata[15:0];
        mteu_pkg::CFG_LOW:    low_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- front of input stage
  // masking, mirroring and offset selection depend only on the incoming
  // reading and static configuration, so they are done ahead of the register
  logic             in_has_off;
  logic [AB-1:0]    in_angle_raw;
  logic [AB-1:0]    in_angle;
  logic [POS_W-1:0] in_zero;
  logic [2*RAW_W-1:0] in_prod;

  always_comb begin
    in_has_off   = in_bus.channel < mteu_pkg::CH_W'(mteu_pkg::OFFSET_REGS);
    in_angle_raw = in_bus.raw_value[AB-1:0];
    in_zero      = '0;
    in_angle     = in_angle_raw;
    if (in_has_off) begin
      in_zero = zero_off_r[in_bus.channel[mteu_pkg::OFF_IDX_W-1:0]];
      if (invert_r[in_bus.channel[mteu_pkg::OFF_IDX_W-1:0]]) begin
        in_angle = mteu_pkg::ANGLE_MASK - in_angle_raw;
      end
    end
    // quotient estimate for the incremental modulus, at most one low
    in_prod = (2*RAW_W)'(in_bus.raw_value) * (2*RAW_W)'(mteu_pkg::INC_RECIP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_ch_r    <= in_bus.channel;
      s1_raw_r   <= in_bus.raw_value;
      s1_quot_r  <= in_prod[2*RAW_W-1:RAW_W];
      s1_angle_r <= in_angle;
      s1_zero_r  <= in_zero;
      s1_a_mz_r  <= POS_W'(in_angle) - in_zero;
    end
  end

  // ---------------------------------------------------------------- unwrap stage
  logic                           is_abs;
  logic                           is_inc;
  logic [mteu_pkg::ABS_IDX_W-1:0] idx;
  logic [AB-1:0]                  last;
  logic [POS_W-1:0]               corr;
  logic [AB-1:0]                  diff;
  logic                           wrap;
  logic [POS_W-1:0]               corr1;
  logic [POS_W-1:0]               pos1;
  logic [POS_W-1:0]               high_ext;
  logic [POS_W-1:0]               low_ext;
  logic                           hi_hit;
  logic                           lo_hit;
  logic [POS_W-1:0]               adj;
  logic [POS_W-1:0]               corr2;
  logic [POS_W-1:0]               pos2;
  logic [POS_W-1:0]               inc_qm;
  logic [POS_W-1:0]               inc_rem;
  logic [POS_W-1:0]               pos_nxt;

  always_comb begin
    is_abs = s1_ch_r < mteu_pkg::CH_W'(mteu_pkg::ABS_CHANNELS);
    is_inc = !is_abs &&
             (s1_ch_r < mteu_pkg::CH_W'(mteu_pkg::ABS_CHANNELS + mteu_pkg::INC_CHANNELS));
    idx    = s1_ch_r[mteu_pkg::ABS_IDX_W-1:0];
    last   = last_angle_r[idx];
    corr   = turn_corr_r[idx];

    // wrap detection on the absolute angle change
    diff = (s1_angle_r > last) ? (s1_angle_r - last) : (last - s1_angle_r);
    wrap = diff > jump_r;
    if (wrap && (s1_angle_r < last)) begin
      corr1 = corr + mteu_pkg::TURN_STEP;
    end else if (wrap) begin
      corr1 = corr - mteu_pkg::TURN_STEP;
    end else begin
      corr1 = corr;
    end
    pos1 = s1_a_mz_r + corr1;

    // limit fold, only with a nonzero offset; both hits cancel out
    high_ext = {{(POS_W-16){high_r[15]}}, high_r};
    low_ext  = {{(POS_W-16){low_r[15]}}, low_r};
    hi_hit   = (s1_zero_r != '0) && ($signed(pos1) > $signed(high_ext));
    lo_hit   = (s1_zero_r != '0) && ($signed(pos1) < $signed(low_ext));
    if (hi_hit && !lo_hit) begin
      adj = '0 - mteu_pkg::TURN_STEP;
    end else if (lo_hit && !hi_hit) begin
      adj = mteu_pkg::TURN_STEP;
    end else begin
      adj = '0;
    end
    corr2 = corr1 + adj;
    pos2  = pos1 + adj;

    // remainder from the quotient estimate, one correction step
    inc_qm  = POS_W'(s1_quot_r) * POS_W'(mteu_pkg::INC_MODULUS);
    inc_rem = POS_W'(s1_raw_r) - inc_qm;
    if (inc_rem >= POS_W'(mteu_pkg::INC_MODULUS)) begin
      inc_rem = inc_rem - POS_W'(mteu_pkg::INC_MODULUS);
    end

    if (is_abs) begin
      pos_nxt = pos2;
    end else if (is_inc) begin
      pos_nxt = inc_rem;
    end else begin
      pos_nxt = '0;
    end
  end

  // state write-back on each absolute-channel transaction that leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mteu_pkg::ABS_CHANNELS; i++) begin
        last_angle_r[i] <= '0;
        turn_corr_r[i]  <= '0;
      end
    end else if (s1_adv && is_abs) begin
      last_angle_r[idx] <= s1_angle_r;
      turn_corr_r[idx]  <= corr2;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_ch_r  <= s1_ch_r;
      out_pos_r <= pos_nxt;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.channel_echo = out_ch_r;
  assign out_bus.position     = $signed(out_pos_r);

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for multi_turn_encoder_unwrap, the per-channel encoder unwrap
// depends on mteu_pkg, mteu_in_if, mteu_out_if and the multi_turn_encoder_unwrap rtl

module tb;

  // cycles without any transaction before the run is declared hung
  localparam int STALL_LIMIT   = 2000;
  // mismatch lines printed before going quiet (counting continues)
  localparam int PRINT_CAP     = 50;
  // readings in the monotonic correction walk
  localparam int WALK_READINGS = 160;

  typedef struct {
    mteu_pkg::chan_t channel_echo;
    mteu_pkg::pos_t  position;
  } position_result_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [mteu_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mteu_pkg::CFG_DATA_W-1:0] cfg_wdata;

  mteu_in_if  in_bus ();
  mteu_out_if out_bus ();

  multi_turn_encoder_unwrap dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // shadow copy of the block: register file and per-channel unwrap state
  logic [mteu_pkg::POS_W-1:0]       model_zero [mteu_pkg::OFFSET_REGS];
  logic [mteu_pkg::OFFSET_REGS-1:0] model_invert = mteu_pkg::INVERT_RST;
  mteu_pkg::angle_t                 model_jump   = mteu_pkg::JUMP_RST;
  logic signed [15:0]               model_high   = mteu_pkg::HIGH_RST;
  logic signed [15:0]               model_low    = mteu_pkg::LOW_RST;
  mteu_pkg::angle_t                 model_angle [mteu_pkg::ABS_CHANNELS];
  logic [mteu_pkg::POS_W-1:0]       model_corr  [mteu_pkg::ABS_CHANNELS];

  position_result_t expected_positions [$];

  int mismatch_count    = 0;
  int readings_sent     = 0;
  int positions_checked = 0;
  int walk_readings     = 0;
  int stall_cycles      = 0;

  // idling knobs, percent of cycles
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // shaft angle that the well-formed random readings follow, per absolute channel
  int shaft [mteu_pkg::ABS_CHANNELS];

  initial begin
    for (int i = 0; i < mteu_pkg::OFFSET_REGS; i++) model_zero[i] = '0;
    for (int i = 0; i < mteu_pkg::ABS_CHANNELS; i++) begin
      model_angle[i] = '0;
      model_corr[i]  = '0;
      shaft[i]       = 0;
    end
  end

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicts one position and advances the shadow state, as the block does
  function automatic position_result_t unwrap_reading(input mteu_pkg::chan_t ch,
                                                      input mteu_pkg::raw_t raw);
    position_result_t           r;
    mteu_pkg::angle_t           a;
    mteu_pkg::angle_t           prev;
    mteu_pkg::angle_t           delta;
    logic [mteu_pkg::POS_W-1:0] corr;
    logic [mteu_pkg::POS_W-1:0] zero;
    mteu_pkg::pos_t             pos;
    r.channel_echo = ch;
    r.position     = '0;
    if (ch < mteu_pkg::ABS_CHANNELS) begin
      a = raw[mteu_pkg::ANGLE_BITS-1:0];
      if (model_invert[ch[mteu_pkg::ABS_IDX_W-1:0]]) a = mteu_pkg::ANGLE_MASK - a;
      prev  = model_angle[ch[mteu_pkg::ABS_IDX_W-1:0]];
      corr  = model_corr[ch[mteu_pkg::ABS_IDX_W-1:0]];
      zero  = model_zero[ch[mteu_pkg::OFF_IDX_W-1:0]];
      delta = (a > prev) ? a - prev : prev - a;
      // a jump past the threshold means the shaft crossed the angle seam
      if (delta > model_jump) begin
        if (a < prev) corr = corr + mteu_pkg::TURN_STEP;
        else if (a > prev) corr = corr - mteu_pkg::TURN_STEP;
      end
      pos = mteu_pkg::POS_W'(a) + corr - zero;
      // limit fold only applies once a zero has been set; both sides use the same pos
      if (zero != '0) begin
        if (pos > model_high) corr = corr - mteu_pkg::TURN_STEP;
        if (pos < model_low) corr = corr + mteu_pkg::TURN_STEP;
      end
      r.position = mteu_pkg::POS_W'(a) + corr - zero;
      model_corr[ch[mteu_pkg::ABS_IDX_W-1:0]]  = corr;
      model_angle[ch[mteu_pkg::ABS_IDX_W-1:0]] = a;
    end else if (ch < mteu_pkg::ABS_CHANNELS + mteu_pkg::INC_CHANNELS) begin
      r.position = mteu_pkg::POS_W'(32'(raw) % 32'(mteu_pkg::INC_MODULUS));
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) $display("[%0t] MISMATCH %s", $realtime, what);
    mismatch_count++;
  endtask

  // result sink: random backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: check the result transaction first, then log the reading transaction,
  // so a same-edge removal and insertion always happen in the same order
  always @(posedge clk) begin
    position_result_t want;
    logic             moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_bus.valid && out_bus.ready) begin
        moved = 1'b1;
        positions_checked++;
        if (expected_positions.size() == 0) begin
          report_mismatch($sformatf("unexpected position %0d on channel %0d",
                                    out_bus.position, out_bus.channel_echo));
        end else begin
          want = expected_positions[0];
          expected_positions.delete(0);
          if (out_bus.channel_echo !== want.channel_echo)
            report_mismatch($sformatf("channel echo %0d, want %0d",
                                      out_bus.channel_echo, want.channel_echo));
          if (out_bus.position !== want.position)
            report_mismatch($sformatf("channel %0d position %0d (%h), want %0d (%h)",
                                      want.channel_echo, out_bus.position, out_bus.position,
                                      want.position, want.position));
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        moved = 1'b1;
        readings_sent++;
        expected_positions.insert(expected_positions.size(),
                                  unwrap_reading(in_bus.channel, in_bus.raw_value));
      end
      // watchdog on transaction activity
      if (moved) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("watchdog: no transaction for %0d cycles, %0d positions outstanding",
                   STALL_LIMIT, expected_positions.size());
          $display("multi_turn_encoder_unwrap regression: fail");
          $finish;
        end
      end
    end
  end

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // one reading transaction; returns on the accepting edge with valid still high,
  // so back-to-back calls drop valid only for the randomly drawn idle cycles
  task automatic send_reading(input mteu_pkg::chan_t ch, input mteu_pkg::raw_t raw);
    cfg_we <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.channel   <= ch;
    in_bus.raw_value <= raw;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // drop valid and let every position drain, plus the two-stage pipe and margin
  task automatic wait_until_idle();
    in_bus.valid <= 1'b0;
    cfg_we       <= 1'b0;
    do @(posedge clk); while (expected_positions.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // register write; only called while idle, so the shadow copy updates at once
  task automatic write_reg(input logic [mteu_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mteu_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      mteu_pkg::CFG_ZERO0, mteu_pkg::CFG_ZERO1,
      mteu_pkg::CFG_ZERO2, mteu_pkg::CFG_ZERO3:
        model_zero[idx[mteu_pkg::OFF_IDX_W-1:0]] = val;
      mteu_pkg::CFG_INVERT: model_invert = val[mteu_pkg::OFFSET_REGS-1:0];
      mteu_pkg::CFG_JUMP:   model_jump   = val[mteu_pkg::ANGLE_BITS-1:0];
      mteu_pkg::CFG_HIGH:   model_high   = val[15:0];
      mteu_pkg::CFG_LOW:    model_low    = val[15:0];
      default: ;
    endcase
  endtask

  // power-on register values: wraps at default threshold, mirrored channels 1 and 2,
  // raw bits above the angle ignored, incremental modulus, unused channels give zero
  task automatic test_reset_defaults();
    send_reading(3'd0, 16'h0000);
    send_reading(3'd0, 16'hFFFF);   // jump up to full scale, one turn down
    send_reading(3'd0, 16'hC000);   // back to zero through the seam, upper bits only
    send_reading(3'd1, 16'h0000);   // mirrored to full scale
    send_reading(3'd2, 16'h3FFF);   // mirrored to zero
    send_reading(3'd3, 16'h8001);
    send_reading(3'd4, 16'hFFFF);
    send_reading(3'd5, 16'd271);
    send_reading(3'd5, 16'd272);
    send_reading(3'd6, 16'hFFFF);
    send_reading(3'd7, 16'h5555);
  endtask

  // zero offsets at the extremes and limits set so one, both or neither fold fires
  task automatic test_offset_limit_folds();
    wait_until_idle();
    write_reg(mteu_pkg::CFG_ZERO0, 32'h8000_0000);
    write_reg(mteu_pkg::CFG_ZERO1, 32'h7FFF_FFFF);
    write_reg(mteu_pkg::CFG_ZERO2, 32'h0000_0001);
    write_reg(mteu_pkg::CFG_ZERO3, 32'hFFFF_FFFF);
    write_reg(mteu_pkg::CFG_INVERT, 32'hF);
    write_reg(mteu_pkg::CFG_JUMP, 32'd0);           // any change counts as a wrap
    write_reg(mteu_pkg::CFG_HIGH, 32'h0000_8000);   // lowest high limit
    write_reg(mteu_pkg::CFG_LOW, 32'h0000_7FFF);    // highest low limit: both folds
    send_reading(3'd0, 16'h1234);
    send_reading(3'd1, 16'h0000);
    send_reading(3'd2, 16'hFFFF);
    send_reading(3'd3, 16'h2AAA);
    send_reading(3'd0, 16'h1233);         // step of one angle count
    wait_until_idle();
    write_reg(mteu_pkg::CFG_ZERO0, 32'd0);
    write_reg(mteu_pkg::CFG_INVERT, 32'h0);
    write_reg(mteu_pkg::CFG_JUMP, 32'd16383);       // never wraps
    write_reg(mteu_pkg::CFG_HIGH, 32'h0000_7FFF);
    write_reg(mteu_pkg::CFG_LOW, 32'h0000_8000);
    send_reading(3'd0, 16'h3FFF);
    send_reading(3'd0, 16'h0000);
    send_reading(3'd1, 16'h3FFF);
    wait_until_idle();
    write_reg(mteu_pkg::CFG_HIGH, 32'd100);
    write_reg(mteu_pkg::CFG_LOW, 32'h0000_FF9C);    // -100
    send_reading(3'd2, 16'h0100);
    send_reading(3'd2, 16'h0000);
    send_reading(3'd3, 16'h3000);
  endtask

  task automatic randomize_settings();
    logic [mteu_pkg::CFG_DATA_W-1:0] z;
    logic [15:0]                     hi;
    logic [15:0]                     lo;
    mteu_pkg::angle_t                j;
    int                              c;
    for (c = 0; c < mteu_pkg::OFFSET_REGS; c++) begin
      case ($urandom_range(7))
        0, 1:    z = '0;
        2, 3:    z = $urandom_range(40000) - 20000;
        4, 5:    z = $urandom();
        6:       z = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        default: z = $urandom_range(1) ? 32'h0000_0001 : 32'hFFFF_FFFF;
      endcase
      write_reg(mteu_pkg::CFG_IDX_W'(mteu_pkg::CFG_ZERO0 + c), z);
    end
    case ($urandom_range(9))
      0:       j = '0;
      1:       j = mteu_pkg::ANGLE_MASK;
      2, 3:    j = mteu_pkg::angle_t'($urandom_range(8000));
      default: j = mteu_pkg::angle_t'($urandom_range(16383, 8000));
    endcase
    if ($urandom_range(2) != 0) begin
      hi = 16'($urandom_range(20000));
      lo = 16'(0 - $urandom_range(20000));
    end else begin
      hi = 16'($urandom());
      lo = 16'($urandom());
    end
    // junk above each register's width must be dropped by the block
    write_reg(mteu_pkg::CFG_INVERT, {28'($urandom()), 4'($urandom())});
    write_reg(mteu_pkg::CFG_JUMP, {18'($urandom()), j});
    write_reg(mteu_pkg::CFG_HIGH, {16'($urandom()), hi});
    write_reg(mteu_pkg::CFG_LOW, {16'($urandom()), lo});
  endtask

  // mostly a shaft turning at random speed (with seam crossings), some incremental
  // counts, and some fully random readings on any channel number
  task automatic test_random_unwrap(input int settings, input int per_setting);
    int              c;
    int              d;
    mteu_pkg::chan_t ch;
    mteu_pkg::raw_t  raw;
    repeat (settings) begin
      wait_until_idle();
      randomize_settings();
      repeat (per_setting) begin
        case ($urandom_range(9))
          0: begin
            ch  = mteu_pkg::chan_t'($urandom());
            raw = mteu_pkg::raw_t'($urandom());
          end
          1: begin
            ch  = mteu_pkg::chan_t'(mteu_pkg::ABS_CHANNELS +
                                    $urandom_range(mteu_pkg::INC_CHANNELS - 1));
            raw = mteu_pkg::raw_t'($urandom());
          end
          default: begin
            c = $urandom_range(mteu_pkg::ABS_CHANNELS - 1);
            case ($urandom_range(9))
              0:       d = $urandom_range(16383);
              1, 2:    d = int'($urandom_range(8000)) - 4000;
              default: d = int'($urandom_range(600)) - 300;
            endcase
            shaft[c] = (shaft[c] + d + 16384) % 16384;
            ch  = mteu_pkg::chan_t'(c);
            raw = {2'($urandom()), mteu_pkg::angle_t'(shaft[c])};
          end
        endcase
        send_reading(ch, raw);
      end
    end
  endtask

  // walk channel 0 down one count per reading with a zero threshold: every
  // reading adds a turn to the correction, except a step across the seam
  task automatic test_correction_walk();
    mteu_pkg::angle_t a;
    wait_until_idle();
    write_reg(mteu_pkg::CFG_ZERO0, '0);
    write_reg(mteu_pkg::CFG_INVERT, {28'($urandom()), 3'($urandom()), 1'b0});
    write_reg(mteu_pkg::CFG_JUMP, '0);
    a = model_angle[0];
    repeat (WALK_READINGS) begin
      a = a - 1'b1;
      send_reading('0, {2'($urandom()), a});
    end
    walk_readings = WALK_READINGS;
  endtask

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_wdata        <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.channel   <= '0;
    in_bus.raw_value <= '0;
    set_idling(26, 50);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_offset_limit_folds();
    test_random_unwrap(3, 180);
    set_idling(50, 26);
    test_random_unwrap(3, 180);
    set_idling(0, 0);
    test_random_unwrap(3, 180);
    test_correction_walk();

    wait_until_idle();
    repeat (8) @(posedge clk);
    if (expected_positions.size() != 0)
      report_mismatch($sformatf("%0d positions never arrived", expected_positions.size()));

    $display("covered %0d readings on all eight channel numbers and %0d positions checked,",
             readings_sent, positions_checked);
    $display("incl. %0d readings walking the turn correction one step each; %0d mismatches",
             walk_readings, mismatch_count);
    if (mismatch_count == 0) begin
      $display("multi_turn_encoder_unwrap regression: pass");
    end else begin
      $display("multi_turn_encoder_unwrap regression: fail");
    end
    $finish;
  end

endmodule

### multi_turn_encoder_unwrap.f
src/mteu_pkg.sv
src/mteu_in_if.sv
src/mteu_out_if.sv
src/multi_turn_encoder_unwrap.sv
verif/tb.sv
